// File: sv/nfha_pkg.sv
// -----------------------------------------------------------------------------
// nfha_pkg
// Shared widths, heap constants and types of the next-fit heap allocator.
// -----------------------------------------------------------------------------
package nfha_pkg;

   localparam int ADDR_W = 16;
   localparam int SIZE_W = 16;
   localparam int SUM_W  = 18;

   localparam logic [SUM_W-1:0] HEAP_BYTES   = 18'd65536;
   localparam logic [SUM_W-1:0] HEADER_BYTES = 18'd16;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [SUM_W-1:0]  sum_type;

   typedef struct packed {
      logic     used;
      size_type size;
   } header_type;

   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      addr_type   addr;
      header_type wdata;
   } mem_req_type;

   typedef struct packed {
      logic     valid;
      addr_type payload_address;
      logic     success;
   } result_type;

endpackage

// File: sv/nfha_req_if.sv
// -----------------------------------------------------------------------------
// nfha_req_if
// Request channel: allocate or free word with valid/ready handshake.
// -----------------------------------------------------------------------------
interface nfha_req_if
   import nfha_pkg::*;
   ();
   logic     valid;
   logic     ready;
   logic     action;
   size_type request_size;
   addr_type free_address;

   modport source (output valid, output action, output request_size,
                   output free_address, input ready);
   modport sink   (input valid, input action, input request_size,
                   input free_address, output ready);
endinterface

// File: sv/nfha_rsp_if.sv
// -----------------------------------------------------------------------------
// nfha_rsp_if
// Response channel: granted payload offset and status word.
// -----------------------------------------------------------------------------
interface nfha_rsp_if
   import nfha_pkg::*;
   ();
   logic     valid;
   logic     ready;
   addr_type payload_address;
   logic     success;

   modport source (output valid, output payload_address, output success,
                   input ready);
   modport sink   (input valid, input payload_address, input success,
                   output ready);
endinterface

// File: sv/nfha_header_mem.sv
// -----------------------------------------------------------------------------
// nfha_header_mem
// Single-port header store, one entry per heap byte, registered read.
// -----------------------------------------------------------------------------
module nfha_header_mem
   import nfha_pkg::*;
   (
   input  logic        clock,
   input  mem_req_type mem_req,
   output header_type  rdata
   );

   header_type mem [0:(1 << ADDR_W) - 1];
   header_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/nfha_ctrl.sv
// -----------------------------------------------------------------------------
// nfha_ctrl
// Sequencer: clearing pass, header chain walk, split and free updates.
// -----------------------------------------------------------------------------
module nfha_ctrl
   import nfha_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   nfha_req_if.sink    req,
   output mem_req_type mem_req,
   input  header_type  mem_rdata,
   output result_type  result,
   input  logic        result_ready
   );

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_START   = 3'd2;
   localparam logic [2:0] S_WALK    = 3'd3;
   localparam logic [2:0] S_FIT     = 3'd4;
   localparam logic [2:0] S_HDR     = 3'd5;
   localparam logic [2:0] S_FREE_WR = 3'd6;
   localparam logic [2:0] S_OUT     = 3'd7;

   logic [2:0] state_ff, state_in;
   addr_type   clr_cnt_ff, clr_cnt_in;
   addr_type   ptr_ff, ptr_in;
   addr_type   u_ff, u_in;
   size_type   req_ff, req_in;
   size_type   size_ff, size_in;
   size_type   final_ff, final_in;
   logic       split_ff, split_in;
   addr_type   res_addr_ff, res_addr_in;
   logic       res_ok_ff, res_ok_in;

   sum_type  u_ext, req_ext, size_ext, final_ext;
   sum_type  start_sum, walk_next, walk_sum, fit_end;
   size_type diff;
   logic     skip;
   logic     accept;

   assign u_ext     = {2'b00, u_ff};
   assign req_ext   = {2'b00, req_ff};
   assign size_ext  = {2'b00, mem_rdata.size};
   assign final_ext = {2'b00, final_ff};
   assign start_sum = u_ext + size_ext + req_ext + (HEADER_BYTES << 1);
   assign walk_next = u_ext + HEADER_BYTES + size_ext;
   assign walk_sum  = walk_next + req_ext;
   assign fit_end   = u_ext + HEADER_BYTES + final_ext;
   assign diff      = mem_rdata.size - req_ff;
   assign skip      = (mem_rdata.size != '0) &&
                      ((mem_rdata.size < req_ff) || mem_rdata.used);

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;

   assign result.valid           = (state_ff == S_OUT);
   assign result.payload_address = res_addr_ff;
   assign result.success         = res_ok_ff;

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      ptr_in      = ptr_ff;
      u_in        = u_ff;
      req_in      = req_ff;
      size_in     = size_ff;
      final_in    = final_ff;
      split_in    = split_ff;
      res_addr_in = res_addr_ff;
      res_ok_in   = res_ok_ff;
      mem_req     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = clr_cnt_ff;
            clr_cnt_in    = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               res_addr_in = '0;
               res_ok_in   = 1'b0;
               if (req.action == ACT_ALLOC) begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = ptr_ff;
                  u_in          = ptr_ff;
                  req_in        = req.request_size;
                  state_in      = S_START;
               end else if ({2'b00, req.free_address} < HEADER_BYTES) begin
                  state_in = S_OUT;
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = req.free_address - HEADER_BYTES[ADDR_W-1:0];
                  u_in          = req.free_address - HEADER_BYTES[ADDR_W-1:0];
                  state_in      = S_FREE_WR;
               end
            end
         end
         S_START: begin
            if (start_sum >= HEAP_BYTES) begin
               state_in = S_OUT;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (skip) begin
               if (walk_sum >= HEAP_BYTES) begin
                  state_in = S_OUT;
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = walk_next[ADDR_W-1:0];
                  u_in          = walk_next[ADDR_W-1:0];
               end
            end else begin
               size_in  = mem_rdata.size;
               state_in = S_FIT;
               if (mem_rdata.size == '0) begin
                  final_in = req_ff;
                  split_in = 1'b0;
               end else if ({2'b00, diff} > (HEADER_BYTES + 1'b1)) begin
                  final_in = req_ff;
                  split_in = 1'b1;
               end else begin
                  final_in = mem_rdata.size;
                  split_in = 1'b0;
               end
            end
         end
         S_FIT: begin
            if ((fit_end + HEADER_BYTES) > HEAP_BYTES) begin
               state_in = S_OUT;
            end else if (split_ff) begin
               mem_req.wr_en      = 1'b1;
               mem_req.addr       = u_ff + HEADER_BYTES[ADDR_W-1:0] + req_ff;
               mem_req.wdata.used = 1'b0;
               mem_req.wdata.size = size_ff - req_ff - HEADER_BYTES[SIZE_W-1:0];
               state_in           = S_HDR;
            end else begin
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            mem_req.wr_en      = 1'b1;
            mem_req.addr       = u_ff;
            mem_req.wdata.used = 1'b1;
            mem_req.wdata.size = final_ff;
            ptr_in             = fit_end[ADDR_W-1:0];
            res_addr_in        = u_ff + HEADER_BYTES[ADDR_W-1:0];
            res_ok_in          = 1'b1;
            state_in           = S_OUT;
         end
         S_FREE_WR: begin
            mem_req.wr_en      = 1'b1;
            mem_req.addr       = u_ff;
            mem_req.wdata.used = 1'b0;
            mem_req.wdata.size = mem_rdata.size;
            ptr_in             = u_ff;
            res_addr_in        = '0;
            res_ok_in          = 1'b1;
            state_in           = S_OUT;
         end
         S_OUT: begin
            if (result_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         ptr_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         ptr_ff     <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff        <= u_in;
      req_ff      <= req_in;
      size_ff     <= size_in;
      final_ff    <= final_in;
      split_ff    <= split_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff   <= res_ok_in;
   end

endmodule

// File: sv/next_fit_heap_allocator.sv
// -----------------------------------------------------------------------------
// next_fit_heap_allocator
// Next-fit byte heap allocator with in-heap headers and block splitting.
//
// req_chan carries one word per item: action (allocate or free), the
// requested size and the payload offset to free. rsp_chan returns exactly
// one word per item: the granted payload offset and a success flag.
// Items are handled one at a time. A free reads the header and writes it
// back marked free; an offset below the header size is rejected with no
// memory access. An allocate runs the start check, walk, fit and header
// write; the header store is a single-port memory with a registered read,
// and each skipped block costs one read. A rejected allocate ends early.
// After reset the header store is cleared one entry a cycle, all 65536
// entries, while req_chan.ready stays low. The response word sits in an
// output register; while the receiver stalls a new request is still taken,
// and its result waits in the sequencer until the register frees up.
// -----------------------------------------------------------------------------
module next_fit_heap_allocator
   import nfha_pkg::*;
   (
   input  logic       clock,
   input  logic       reset,
   nfha_req_if.sink   req_chan,
   nfha_rsp_if.source rsp_chan
   );

   mem_req_type mem_req;
   header_type  mem_rdata;
   result_type  result;
   logic        slot_free;

   logic     rsp_valid_ff, rsp_valid_in;
   addr_type rsp_addr_ff, rsp_addr_in;
   logic     rsp_ok_ff, rsp_ok_in;

   nfha_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .mem_req      (mem_req),
      .mem_rdata    (mem_rdata),
      .result       (result),
      .result_ready (slot_free)
   );

   nfha_header_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (result.valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = result.payload_address;
         rsp_ok_in    = result.success;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.payload_address = rsp_addr_ff;
   assign rsp_chan.success         = rsp_ok_ff;

endmodule

// File: sim/next_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// next_fit_heap_allocator_tb
// Self-checking bench for the next-fit heap allocator.
//
// A table of directed allocate and free words covers the error returns, exact
// fits, splits, walk overruns and the heap end. Random traffic follows: mostly
// allocations and frees of granted blocks, with some stray frees. A model
// of the header chain and search pointer predicts each response word the
// table leaves open. Sender bursts and receiver stall patterns are random.
// -----------------------------------------------------------------------------
module next_fit_heap_allocator_tb;
   import nfha_pkg::*;

   localparam longint HEAP = longint'(HEAP_BYTES);
   localparam longint HDR  = longint'(HEADER_BYTES);
   localparam int RANDOM_WORDS = 1450;

   typedef struct packed {
      logic     act;
      size_type size;
      addr_type addr;
      logic     known;
      addr_type exp_addr;
      logic     exp_ok;
   } op_row_type;

   typedef struct packed {
      addr_type payload_address;
      logic     success;
   } grant_type;

   logic clock;
   logic reset;

   nfha_req_if req_chan ();
   nfha_rsp_if rsp_chan ();

   next_fit_heap_allocator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   header_type heap_hdr [0:65535];
   longint     scan_ptr;
   grant_type  pending_grants [$];
   addr_type   live_blocks [$];
   int         errors;
   int         burst_left;

   op_row_type directed_ops [0:26] = '{
      '{ACT_ALLOC, 16'd0,     16'd0,     1'b1, 16'd16, 1'b1},
      '{ACT_ALLOC, 16'd65535, 16'd0,     1'b1, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd0,     1'b1, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd15,    1'b1, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd16,    1'b1, 16'd0,  1'b1},
      '{ACT_ALLOC, 16'd0,     16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd100,   16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd50,    16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd32,    1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd10,    16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd74,    16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd58,    1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd60,    16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd32,    1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd65400, 16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd40016, 1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd10,    16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd25000, 16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd40016, 1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd10,    16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd470,   16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd65016, 1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd400,   16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd88,    16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_ALLOC, 16'd87,    16'd0,     1'b0, 16'd0,  1'b0},
      '{ACT_FREE,  16'd0,     16'd65535, 1'b1, 16'd0,  1'b1},
      '{ACT_ALLOC, 16'd0,     16'd0,     1'b1, 16'd0,  1'b0}
   };

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void model_alloc(input longint req, output grant_type res);
      longint u;
      longint sz;
      longint fin;
      res = '0;
      u = scan_ptr;
      if (u >= HEAP) return;
      sz = longint'(heap_hdr[u].size);
      if (u + sz + req + 2 * HDR >= HEAP) return;
      while (sz != 0 && (sz < req || heap_hdr[u].used)) begin
         if (u + HDR + sz + req >= HEAP) return;
         u  = u + HDR + sz;
         sz = longint'(heap_hdr[u].size);
      end
      fin = (sz == 0 || sz - req > HDR + 1) ? req : sz;
      if (u + HDR + fin + HDR > HEAP) return;
      if (sz != 0 && sz - req > HDR + 1) begin
         heap_hdr[u + HDR + req] = '{used: 1'b0, size: size_type'(sz - req - HDR)};
      end
      heap_hdr[u] = '{used: 1'b1, size: size_type'(fin)};
      scan_ptr = u + HDR + fin;
      res = '{payload_address: addr_type'(u + HDR), success: 1'b1};
   endfunction

   function automatic void model_free(input longint fa, output grant_type res);
      res = '0;
      if (fa < HDR || fa - HDR >= HEAP) return;
      heap_hdr[fa - HDR].used = 1'b0;
      scan_ptr = fa - HDR;
      res.success = 1'b1;
   endfunction

   task automatic push_word(input logic act, input size_type sz, input addr_type fa,
                            input logic known, input grant_type typed);
      grant_type res;
      req_chan.valid        <= 1'b1;
      req_chan.action       <= act;
      req_chan.request_size <= sz;
      req_chan.free_address <= fa;
      do @(negedge clock); while (!req_chan.ready);
      if (act == ACT_ALLOC) begin
         model_alloc(longint'(sz), res);
         if (res.success) live_blocks.push_back(res.payload_address);
      end else begin
         model_free(longint'(fa), res);
      end
      pending_grants.push_back(known ? typed : res);
      @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   // receiver stall pattern from a random 16-bit mask, redrawn repeatedly
   initial begin
      logic [15:0] stall_mask;
      int          phase;
      stall_mask = '1;
      phase      = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase % 128 == 0) begin
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
         end
         rsp_chan.ready <= stall_mask[phase % 16];
         phase++;
      end
   end

   always @(negedge clock) begin
      grant_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected word, actual addr=%0d success=%0b", $time,
                     rsp_chan.payload_address, rsp_chan.success);
            errors++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_chan.payload_address !== want.payload_address) begin
               $display("%0t: payload_address expected %0d actual %0d", $time,
                        want.payload_address, rsp_chan.payload_address);
               errors++;
            end
            if (rsp_chan.success !== want.success) begin
               $display("%0t: success expected %0b actual %0b", $time,
                        want.success, rsp_chan.success);
               errors++;
            end
         end
      end
   end

   initial begin
      #1000000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int       sel;
      int       idx;
      size_type sz;
      foreach (heap_hdr[i]) heap_hdr[i] = '0;
      scan_ptr   = 0;
      errors     = 0;
      burst_left = 1;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.action       <= ACT_ALLOC;
      req_chan.request_size <= '0;
      req_chan.free_address <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i]) begin
         push_word(directed_ops[i].act, directed_ops[i].size, directed_ops[i].addr,
                   directed_ops[i].known,
                   '{payload_address: directed_ops[i].exp_addr,
                     success: directed_ops[i].exp_ok});
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 5) begin
            push_word(ACT_FREE, size_type'($urandom()),
                      ($urandom_range(0, 3) == 0) ? addr_type'($urandom_range(0, 31))
                                                  : addr_type'($urandom()),
                      1'b0, '0);
         end else if (live_blocks.size() > 0 &&
                      sel < (live_blocks.size() > 200 ? 65 : 45)) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            push_word(ACT_FREE, size_type'($urandom()), live_blocks[idx], 1'b0, '0);
            live_blocks.delete(idx);
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < 70)      sz = size_type'($urandom_range(0, 255));
            else if (sel < 90) sz = size_type'($urandom_range(0, 4095));
            else               sz = size_type'($urandom());
            push_word(ACT_ALLOC, sz, addr_type'($urandom()), 1'b0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
